// ===== hdl/serial_line_editor_with_echo_assert.svh =====
// ----------------------------------------------------------------------------
// Line editor assertion macros
// Shorthand for the concurrent checks of the line editor. Every check is
// clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LINE_EDITOR_WITH_ECHO_ASSERT_SVH
`define SERIAL_LINE_EDITOR_WITH_ECHO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Line editor package
// Shared types, character codes and register indexes of the line editor.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int unsigned MAX_LINE  = 256;
    localparam int unsigned CAP_LIMIT = (MAX_LINE > 256) ? 256 : MAX_LINE;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_CHAR_FILTER   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_CAPACITY = 1'b1;

    localparam logic [1:0] FILTER_ANY     = 2'd0;
    localparam logic [1:0] FILTER_LETTERS = 2'd1;
    localparam logic [1:0] FILTER_DIGITS  = 2'd2;
    localparam logic [1:0] FILTER_ALNUM   = 2'd3;

    typedef logic [7:0] byte_t;
    typedef logic [7:0] pos_t;
    typedef logic [1:0] step_t;

    localparam byte_t CH_NUL = 8'h00;
    localparam byte_t CH_BS  = 8'h08;
    localparam byte_t CH_LF  = 8'h0A;
    localparam byte_t CH_CR  = 8'h0D;
    localparam byte_t CH_SP  = 8'h20;
    localparam byte_t CH_DEL = 8'h7F;
    localparam byte_t CH_UP_A = 8'd65;
    localparam byte_t CH_UP_Z = 8'd90;
    localparam byte_t CH_LO_A = 8'd97;
    localparam byte_t CH_LO_Z = 8'd122;
    localparam byte_t CH_D0   = 8'd48;
    localparam byte_t CH_D9   = 8'd57;

    localparam logic [8:0] CAPACITY_RESET = 9'd256;

    typedef struct packed {
        logic [1:0] filter;
        pos_t       limit;
    } cfg_t;

    typedef struct packed {
        logic  echo_valid;
        byte_t echo_byte;
        logic  store_valid;
        pos_t  store_index;
        byte_t store_byte;
        logic  line_done;
        pos_t  line_length;
        logic  last;
    } res_t;

    typedef struct packed {
        step_t count;
        pos_t  next_pos;
        res_t  res;
    } dec_t;

endpackage

// ===== hdl/sle_if.sv =====
// ----------------------------------------------------------------------------
// Line editor channels
// Valid/ready channels for received bytes and for editor results.
// ----------------------------------------------------------------------------
interface sle_rx_if;
    import sle_pkg::*;

    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sle_res_if;
    import sle_pkg::*;

    logic  valid;
    logic  ready;
    logic  echo_valid;
    byte_t echo_byte;
    logic  store_valid;
    pos_t  store_index;
    byte_t store_byte;
    logic  line_done;
    pos_t  line_length;
    logic  last;

    modport source (
        output valid, output echo_valid, output echo_byte, output store_valid,
        output store_index, output store_byte, output line_done,
        output line_length, output last, input ready
    );
    modport sink (
        input valid, input echo_valid, input echo_byte, input store_valid,
        input store_index, input store_byte, input line_done,
        input line_length, input last, output ready
    );
endinterface

// ===== hdl/sle_cfg.sv =====
// ----------------------------------------------------------------------------
// Line editor configuration
// Holds the character filter and the line capacity, and keeps a registered
// copy of the last usable position derived from the clamped capacity.
// ----------------------------------------------------------------------------
module sle_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sle_pkg::CFG_DATA_W-1:0] cfg_data,
    output sle_pkg::cfg_t                  cfg
);
    import sle_pkg::*;

    localparam logic [8:0] CAP_MAX = 9'(CAP_LIMIT);

    logic [1:0] filter_reg;
    logic [1:0] filter_next;
    logic [8:0] capacity_reg;
    logic [8:0] capacity_next;
    pos_t       limit_reg;
    pos_t       limit_next;
    logic [8:0] cap_clamped;

    always_comb
    begin
        filter_next   = filter_reg;
        capacity_next = capacity_reg;
        if (cfg_we)
        begin
            if (cfg_index == CFG_CHAR_FILTER)
            begin
                filter_next = cfg_data[1:0];
            end
            if (cfg_index == CFG_LINE_CAPACITY)
            begin
                capacity_next = cfg_data;
            end
        end
    end

    always_comb
    begin
        cap_clamped = capacity_reg;
        if (cap_clamped < 9'd2)
        begin
            cap_clamped = 9'd2;
        end
        if (cap_clamped > CAP_MAX)
        begin
            cap_clamped = CAP_MAX;
        end
        limit_next = 8'(cap_clamped - 9'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg   <= FILTER_ANY;
            capacity_reg <= CAPACITY_RESET;
            limit_reg    <= 8'(CAP_MAX - 9'd1);
        end
        else
        begin
            filter_reg   <= filter_next;
            capacity_reg <= capacity_next;
            limit_reg    <= limit_next;
        end
    end

    assign cfg.filter = filter_reg;
    assign cfg.limit  = limit_reg;

endmodule

// ===== hdl/sle_decode.sv =====
// ----------------------------------------------------------------------------
// Line editor decoder
// Classifies the held byte and forms the result of the current step, the
// number of results the byte causes and the write position that follows.
// ----------------------------------------------------------------------------
module sle_decode (
    input  sle_pkg::byte_t rx_byte,
    input  sle_pkg::pos_t  pos,
    input  sle_pkg::step_t step,
    input  sle_pkg::cfg_t  cfg,
    output sle_pkg::dec_t  dec
);
    import sle_pkg::*;

    logic       is_erase;
    logic       is_eol;
    logic       is_letter;
    logic       is_digit;
    logic       ok;
    logic [8:0] pos_inc;
    logic       full;

    always_comb
    begin
        is_erase  = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
        is_eol    = (rx_byte == CH_CR) || (rx_byte == CH_LF);
        is_letter = ((rx_byte >= CH_UP_A) && (rx_byte <= CH_UP_Z))
                 || ((rx_byte >= CH_LO_A) && (rx_byte <= CH_LO_Z));
        is_digit  = (rx_byte >= CH_D0) && (rx_byte <= CH_D9);
        unique case (cfg.filter)
            FILTER_ANY:     ok = 1'b1;
            FILTER_LETTERS: ok = is_letter;
            FILTER_DIGITS:  ok = is_digit;
            FILTER_ALNUM:   ok = is_letter || is_digit;
        endcase
        pos_inc = {1'b0, pos} + 9'd1;
        full    = pos_inc >= {1'b0, cfg.limit};
    end

    always_comb
    begin
        dec          = '0;
        dec.next_pos = pos;
        if (is_erase)
        begin
            if (pos != '0)
            begin
                dec.count          = 2'd3;
                dec.next_pos       = pos - 8'd1;
                dec.res.echo_valid = 1'b1;
                dec.res.echo_byte  = (step == 2'd1) ? CH_SP : CH_BS;
            end
        end
        else if (is_eol)
        begin
            dec.count          = 2'd2;
            dec.next_pos       = '0;
            dec.res.echo_valid = 1'b1;
            if (step == 2'd0)
            begin
                dec.res.echo_byte   = CH_CR;
                dec.res.store_valid = 1'b1;
                dec.res.store_index = pos;
                dec.res.store_byte  = CH_NUL;
            end
            else
            begin
                dec.res.echo_byte   = CH_LF;
                dec.res.line_done   = 1'b1;
                dec.res.line_length = pos;
            end
        end
        else if (ok)
        begin
            dec.count    = full ? 2'd2 : 2'd1;
            dec.next_pos = full ? '0 : pos_inc[7:0];
            if (step == 2'd0)
            begin
                dec.res.echo_valid  = 1'b1;
                dec.res.echo_byte   = rx_byte;
                dec.res.store_valid = 1'b1;
                dec.res.store_index = pos;
                dec.res.store_byte  = rx_byte;
            end
            else
            begin
                dec.res.store_valid = 1'b1;
                dec.res.store_index = pos_inc[7:0];
                dec.res.store_byte  = CH_NUL;
                dec.res.line_done   = 1'b1;
                dec.res.line_length = pos_inc[7:0];
            end
        end
        dec.res.last = (dec.count != 2'd0) && (step == dec.count - 2'd1);
    end

endmodule

// ===== hdl/serial_line_editor_with_echo.sv =====
// ----------------------------------------------------------------------------
// Serial line editor with echo
// A received byte is held in an input register while its results, up to
// three, leave through an output register, one result per cycle while the
// result channel is ready; a result that waits also holds the byte behind it.
// A byte gives no result if it is filtered or is an erase on an empty line,
// one if it is a stored byte that does not end the line, two for a line end
// or a byte that fills the line, and three for an erase. The next byte is
// taken in the same cycle as the last result of the previous one. The decoder
// reads the registered write position directly, so no byte waits on another.
// A new filter takes effect in the cycle after it is written; a new capacity
// acts only after passing through the capacity register and the limit register.
// ----------------------------------------------------------------------------
module serial_line_editor_with_echo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sle_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sle_pkg::CFG_DATA_W-1:0] cfg_data,
    sle_rx_if.sink                         rx,
    sle_res_if.source                      res
);
    import sle_pkg::*;

    cfg_t  cfg;
    dec_t  dec;

    logic  in_valid_reg;
    logic  in_valid_next;
    byte_t in_byte_reg;
    byte_t in_byte_next;
    step_t step_reg;
    step_t step_next;
    pos_t  pos_reg;
    pos_t  pos_next;
    logic  out_valid_reg;
    logic  out_valid_next;
    res_t  out_reg;
    res_t  out_next;

    logic  out_free;
    logic  emit;
    logic  retire;
    logic  accept;

    sle_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sle_decode u_decode (
        .rx_byte (in_byte_reg),
        .pos     (pos_reg),
        .step    (step_reg),
        .cfg     (cfg),
        .dec     (dec)
    );

    always_comb
    begin
        out_free = !out_valid_reg || res.ready;
        emit     = in_valid_reg && (dec.count != 2'd0) && out_free;
        retire   = in_valid_reg && ((dec.count == 2'd0) || (emit && dec.res.last));
        accept   = rx.valid && rx.ready;
    end

    assign rx.ready = !in_valid_reg || retire;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (retire)
        begin
            in_valid_next = 1'b0;
            step_next     = '0;
            pos_next      = dec.next_pos;
        end
        else if (emit)
        begin
            step_next = step_reg + 2'd1;
        end

        if (accept)
        begin
            in_valid_next = 1'b1;
            in_byte_next  = rx.rx_byte;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_next       = dec.res;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            step_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.echo_valid  = out_reg.echo_valid;
    assign res.echo_byte   = out_reg.echo_byte;
    assign res.store_valid = out_reg.store_valid;
    assign res.store_index = out_reg.store_index;
    assign res.store_byte  = out_reg.store_byte;
    assign res.line_done   = out_reg.line_done;
    assign res.line_length = out_reg.line_length;
    assign res.last        = out_reg.last;

`include "serial_line_editor_with_echo_assert.svh"

    `SLE_ASSERT_SAME(a_step_in_range, in_valid_reg && (dec.count != 2'd0),
        step_reg < dec.count, "result step beyond the result count of the item")
    `SLE_ASSERT_SAME(a_step_needs_item, step_reg != 2'd0,
        in_valid_reg, "result step advanced with no item held")
    `SLE_ASSERT_NEXT(a_line_end_resets_pos,
        retire && ((in_byte_reg == CH_CR) || (in_byte_reg == CH_LF)),
        pos_reg == '0, "write position not cleared after a line end")

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Line editor testbench
// Sends received bytes into the line editor and checks every echo, buffer
// store and line completion against a cycle-free model of the editor. The
// run goes through several filter and capacity settings, each written while
// the editor is idle, and both channels stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    import sle_pkg::*;

    localparam int unsigned HALF_PERIOD = 6;
    localparam int unsigned TAIL_CYCLES = 4;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned REPORT_MAX  = 10;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sle_rx_if  rx_ch ();
    sle_res_if res_ch ();

    byte_t       rx_pending[$];
    res_t        want_q[$];
    logic [1:0]  filter_sel;
    logic [8:0]  cap_reg;
    pos_t        cursor;
    bit          rx_took;
    bit          steady;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    serial_line_editor_with_echo i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx_ch),
        .res       (res_ch)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic void edit_line(byte_t c);
        int unsigned cap;
        int unsigned nxt;
        logic        is_alpha;
        logic        is_num;
        logic        keep;
        cap = 32'(cap_reg);
        if (cap < 2)
            cap = 2;
        if (cap > CAP_LIMIT)
            cap = CAP_LIMIT;
        if (c == CH_BS || c == CH_DEL)
        begin
            if (cursor == 0)
                return;
            cursor = cursor - 8'd1;
            want_q.push_back('{1'b1, CH_BS, 1'b0, 8'd0, CH_NUL, 1'b0, 8'd0, 1'b0});
            want_q.push_back('{1'b1, CH_SP, 1'b0, 8'd0, CH_NUL, 1'b0, 8'd0, 1'b0});
            want_q.push_back('{1'b1, CH_BS, 1'b0, 8'd0, CH_NUL, 1'b0, 8'd0, 1'b1});
            return;
        end
        if (c == CH_CR || c == CH_LF)
        begin
            want_q.push_back('{1'b1, CH_CR, 1'b1, cursor, CH_NUL, 1'b0, 8'd0, 1'b0});
            want_q.push_back('{1'b1, CH_LF, 1'b0, 8'd0, CH_NUL, 1'b1, cursor, 1'b1});
            cursor = 8'd0;
            return;
        end
        is_alpha = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
        is_num   = (c >= CH_D0 && c <= CH_D9);
        case (filter_sel)
            FILTER_LETTERS: keep = is_alpha;
            FILTER_DIGITS:  keep = is_num;
            FILTER_ALNUM:   keep = is_alpha || is_num;
            default:        keep = 1'b1;
        endcase
        if (!keep)
            return;
        nxt = 32'(cursor) + 32'd1;
        if (nxt >= cap - 1)
        begin
            want_q.push_back('{1'b1, c, 1'b1, cursor, c, 1'b0, 8'd0, 1'b0});
            want_q.push_back('{1'b0, CH_NUL, 1'b1, pos_t'(nxt), CH_NUL, 1'b1, pos_t'(nxt),
                               1'b1});
            cursor = 8'd0;
        end
        else
        begin
            want_q.push_back('{1'b1, c, 1'b1, cursor, c, 1'b0, 8'd0, 1'b1});
            cursor = pos_t'(nxt);
        end
    endfunction

    function automatic string show_result(res_t r);
        return $sformatf("echo %0b/%02h store %0b/%0d/%02h done %0b/%0d last %0b",
                         r.echo_valid, r.echo_byte, r.store_valid, r.store_index,
                         r.store_byte, r.line_done, r.line_length, r.last);
    endfunction

    task automatic note_error(string msg);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("ERROR: %s", msg);
    endtask

    function automatic byte_t class_char(logic [1:0] sel);
        byte_t letter;
        byte_t digit;
        letter = $urandom_range(0, 1) ? byte_t'(CH_UP_A + $urandom_range(0, 25))
                                      : byte_t'(CH_LO_A + $urandom_range(0, 25));
        digit  = byte_t'(CH_D0 + $urandom_range(0, 9));
        case (sel)
            FILTER_LETTERS: return letter;
            FILTER_DIGITS:  return digit;
            FILTER_ALNUM:   return $urandom_range(0, 1) ? letter : digit;
            default:        return byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_random(int unsigned count, logic [1:0] sel);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 58)
                rx_pending.push_back(class_char(sel));
            else if (pick < 70)
                rx_pending.push_back($urandom_range(0, 1) ? CH_BS : CH_DEL);
            else if (pick < 80)
                rx_pending.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
            else
                rx_pending.push_back(byte_t'($urandom_range(0, 255)));
        end
    endtask

    task automatic set_regs(logic [1:0] sel, logic [8:0] cap);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CHAR_FILTER;
        cfg_data  <= CFG_DATA_W'(sel);
        @(negedge clk);
        cfg_index <= CFG_LINE_CAPACITY;
        cfg_data  <= cap;
        @(negedge clk);
        cfg_we <= 1'b0;
        filter_sel = sel;
        cap_reg    = cap;
        @(negedge clk);
    endtask

    task automatic drain();
        while (rx_pending.size() != 0 || rx_ch.valid === 1'b1 || want_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (rx_ch.valid !== 1'b1 || rx_took)
            begin
                if (rx_pending.size() != 0 && (steady || $urandom_range(0, 99) >= 32))
                begin
                    rx_ch.rx_byte <= rx_pending.pop_front();
                    rx_ch.valid   <= 1'b1;
                end
                else
                    rx_ch.valid <= 1'b0;
            end
            rx_took = 1'b0;
        end
    end

    always @(negedge clk)
        res_ch.ready <= steady || ($urandom_range(0, 99) >= 32);

    always @(posedge clk)
    begin : monitor
        res_t got;
        res_t exp;
        bit   moved;
        moved = 1'b0;
        if (rst_n === 1'b1)
        begin
            if (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1)
            begin
                edit_line(rx_ch.rx_byte);
                rx_took = 1'b1;
                moved   = 1'b1;
            end
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                moved = 1'b1;
                got = '{res_ch.echo_valid, res_ch.echo_byte, res_ch.store_valid,
                        res_ch.store_index, res_ch.store_byte, res_ch.line_done,
                        res_ch.line_length, res_ch.last};
                if (want_q.size() == 0)
                    note_error({"result with nothing expected: ", show_result(got)});
                else
                begin
                    exp = want_q.pop_front();
                    if (got !== exp)
                        note_error({"expected ", show_result(exp), ", got ",
                                    show_result(got)});
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("serial_line_editor_with_echo test failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_CHAR_FILTER;
        cfg_data      = '0;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = CH_NUL;
        res_ch.ready  = 1'b0;
        rx_took       = 1'b0;
        steady        = 1'b0;
        filter_sel    = FILTER_ANY;
        cap_reg       = CAPACITY_RESET;
        cursor        = 8'd0;
        mismatches    = 0;
        quiet_cycles  = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Erase on an empty line, extreme byte values, erase, and an empty line.
        rx_pending = '{CH_BS, CH_DEL, CH_UP_A, 8'h00, 8'hFF, CH_BS, CH_DEL, CH_CR,
                       CH_LF, CH_D0, CH_LF};
        drain();

        // Small capacity fills the line; a filtered byte in between.
        set_regs(FILTER_LETTERS, 9'd3);
        rx_pending = '{CH_LO_A, CH_D0, CH_UP_Z};
        drain();
        set_regs(FILTER_ANY, 9'd0);
        rx_pending = '{8'h78};
        drain();
        set_regs(FILTER_DIGITS, 9'd511);
        rx_pending = '{CH_D9, CH_LO_Z, CH_CR};
        drain();
        set_regs(FILTER_ALNUM, 9'd1);
        rx_pending = '{8'h51, 8'h21};
        drain();

        // Capacity lowered below the current position in the middle of a line.
        set_regs(FILTER_ALNUM, 9'd256);
        for (int i = 0; i < 5; i++)
            rx_pending.push_back(byte_t'(CH_LO_A + i));
        drain();
        set_regs(FILTER_ALNUM, 9'd4);
        rx_pending = '{CH_D9};
        drain();

        for (int phase = 0; phase < 5; phase++)
        begin
            int unsigned pick;
            logic [8:0]  cap;
            logic [1:0]  sel;
            pick = $urandom_range(0, 99);
            if (pick < 55)
                cap = 9'($urandom_range(2, 12));
            else if (pick < 70)
                cap = 9'($urandom_range(0, 1));
            else if (pick < 80)
                cap = 9'($urandom_range(257, 511));
            else
                cap = 9'($urandom_range(13, 256));
            sel = 2'($urandom_range(0, 3));
            set_regs(sel, cap);
            steady = (phase == 2);
            add_random(28, sel);
            drain();
            steady = 1'b0;
        end

        // One long line that fills a larger buffer.
        set_regs(FILTER_LETTERS, 9'd64);
        repeat (63) rx_pending.push_back(class_char(FILTER_LETTERS));
        drain();

        if (want_q.size() != 0)
            note_error($sformatf("%0d expected results never arrived", want_q.size()));
        if (mismatches == 0)
            $display("serial_line_editor_with_echo test passed");
        else
            $display("serial_line_editor_with_echo test failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/sle_pkg.sv
hdl/sle_if.sv
hdl/sle_cfg.sv
hdl/sle_decode.sv
hdl/serial_line_editor_with_echo.sv
tb/sv/tb_top.sv
